FILE: sv/saturation_weighted_glow_unit_macros.svh
// Assertion macros for the saturation weighted glow unit.
// Used by the top level only; no other dependencies.
`ifndef SATURATION_WEIGHTED_GLOW_UNIT_MACROS_SVH
`define SATURATION_WEIGHTED_GLOW_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SWG_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SWG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/swg_pkg.sv
// Shared constants, stage positions and payload types of the glow unit.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package swg_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Q1.30 gain arithmetic; the factor width FW holds Q2.30
	localparam int QB = 30;
	localparam int QW = QB + 1;
	localparam logic [QW-1:0] ONE = {1'b1, {QB{1'b0}}};
	localparam int FW = QW + 1;

	// root of the chroma radicand
	localparam int RAD_W = 64;
	localparam int SQ_STEPS = RAD_W / 2;

	localparam int SUM_W = 34;
	localparam int NW = 40;
	localparam int CW = 64;
	localparam int WDIV_W = 58;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_MID = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 2'd3;
	localparam logic DIRECTION_RST = 1'b0;
	localparam logic [15:0] GLOW_GAIN_RST = 16'd4915;
	localparam logic [15:0] GLOW_MID_RST = 16'd6554;
	localparam logic [15:0] NOISE_FLOOR_RST = 16'd655;

	// stage positions (register outputs)
	localparam int ST_SAT = 1 + QB;
	localparam int ST_G = ST_SAT + 3;
	localparam int ST_T = 3 + SQ_STEPS;
	localparam int ST_FLAG = ST_T + 2;
	localparam int ST_W = ST_FLAG + QB;
	localparam int ST_P = ST_W + 1;
	localparam int ST_Q2 = ST_P + QB;
	localparam int ST_FAC = ST_Q2 + 1;
	localparam int ST_OUT = ST_FAC + 2;

	localparam int D_G_ALIGN = ST_T - ST_G;
	localparam int D_PIX_A = ST_T - 1;
	localparam int D_PIX_B = ST_FAC - ST_T;
	localparam int D_G_A = ST_W - ST_T;
	localparam int D_G_B = ST_Q2 - ST_W;
	localparam int D_FLAG = ST_Q2 - ST_FLAG;
	localparam int D_Q0 = ST_Q2 - (ST_T + QB);
	localparam int D_P = ST_Q2 - ST_P;

	typedef struct packed {
		logic signed [31:0] red_in;
		logic signed [31:0] green_in;
		logic signed [31:0] blue_in;
		logic signed [31:0] alpha_in;
		logic last_in;
	} pix_in_t;

	typedef struct packed {
		logic signed [31:0] red_out;
		logic signed [31:0] green_out;
		logic signed [31:0] blue_out;
		logic signed [31:0] alpha_out;
		logic last_out;
	} pix_out_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic [31:0] alpha;
		logic signed [31:0] r;
		logic signed [31:0] g;
		logic signed [31:0] b;
		logic signed [SUM_W-1:0] sum3;
	} pix_t;

	typedef struct packed {
		logic ge24;
		logic le8;
		logic lethr;
	} path_t;

endpackage

`default_nettype wire

FILE: sv/swg_stream_if.sv
// Valid/ready stream channel with a typed payload.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface swg_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/swg_delay.sv
// Enabled shift line that carries a word a fixed number of stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swg_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

`default_nettype wire

FILE: sv/swg_div.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
// Depends on swg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swg_div #(
	parameter int W = 32
) (
	input logic clk,
	input logic en,
	input logic [W-1:0] num,
	input logic [W-1:0] den,
	output logic [swg_pkg::QW-1:0] quo
);
	import swg_pkg::*;

	logic [W-1:0] rem_s [QB];
	logic [W-1:0] den_s [QB];
	logic [QB-1:0] quo_s [QB];
	logic sat_s [QB];

	generate
		for (genvar k = 0; k < QB; k++) begin : g_step
			logic [W-1:0] rem_in;
			logic [W-1:0] den_in;
			logic [QB-1:0] quo_in;
			logic sat_in;
			logic [W:0] dbl;
			logic [W:0] diff;

			if (k == 0) begin : g_first
				assign rem_in = num;
				assign den_in = den;
				assign quo_in = '0;
				assign sat_in = (num >= den);
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign den_in = den_s[k-1];
				assign quo_in = quo_s[k-1];
				assign sat_in = sat_s[k-1];
			end

			assign dbl = {rem_in, 1'b0};
			assign diff = dbl - {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= den_in;
					sat_s[k] <= sat_in;
					if (!diff[W]) begin
						rem_s[k] <= diff[W-1:0];
						quo_s[k] <= {quo_in[QB-2:0], 1'b1};
					end else begin
						rem_s[k] <= dbl[W-1:0];
						quo_s[k] <= {quo_in[QB-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	assign quo = sat_s[QB-1] ? ONE : {1'b0, quo_s[QB-1]};

endmodule

`default_nettype wire

FILE: sv/swg_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on swg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swg_sqrt (
	input logic clk,
	input logic en,
	input logic [swg_pkg::RAD_W-1:0] rad,
	output logic [swg_pkg::SQ_STEPS-1:0] root
);
	import swg_pkg::*;

	logic [RAD_W-1:0] x_s [SQ_STEPS];
	logic [RAD_W-1:0] res_s [SQ_STEPS];

	generate
		for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
			localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
			logic [RAD_W-1:0] x_in;
			logic [RAD_W-1:0] res_in;
			logic [RAD_W-1:0] trial;

			if (k == 0) begin : g_first
				assign x_in = rad;
				assign res_in = '0;
			end else begin : g_next
				assign x_in = x_s[k-1];
				assign res_in = res_s[k-1];
			end

			assign trial = res_in + BIT;

			always_ff @(posedge clk) begin
				if (en) begin
					if (x_in >= trial) begin
						x_s[k] <= x_in - trial;
						res_s[k] <= (res_in >> 1) + BIT;
					end else begin
						x_s[k] <= x_in;
						res_s[k] <= res_in >> 1;
					end
				end
			end
		end
	endgenerate

	assign root = res_s[SQ_STEPS-1][SQ_STEPS-1:0];

endmodule

`default_nettype wire

FILE: sv/saturation_weighted_glow_unit.sv
// Saturation weighted glow unit: scales R, G and B of each pixel by a glow
// factor taken from luma-plus-chroma and a sigmoid of saturation; alpha and
// the last mark pass through. One pixel enters per clock while the output is not
// stalled; a pixel accepted at the input sits in the output register after 101
// register stages counting the entry register. The depth is set by the 32-step
// chroma root followed by two 30-step fraction dividers in series, each retiring
// one bit per stage. A stall at the output holds the whole pipeline; input ready
// is high when the output register is empty or taken.
`timescale 1ns / 1ps
`default_nettype none
`include "saturation_weighted_glow_unit_macros.svh"

module saturation_weighted_glow_unit #(
	parameter int FRAC_BITS = swg_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [swg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [swg_pkg::CFG_DATA_W-1:0] cfg_data,
	swg_stream_if.sink pix_in,
	swg_stream_if.source pix_out
);
	import swg_pkg::*;

	localparam int NFW = 16 + FRAC_BITS;
	localparam int DEN_W = (NFW > 31) ? NFW : 31;
	localparam int TW = 16 + QW + 3 + FRAC_BITS;
	localparam int XW = QB + 4;
	localparam int GPW = 16 + QW;
	localparam logic [63:0] RND = 64'(1) << (QB - 1);

	logic dir_q;
	logic [15:0] gain_q;
	logic [15:0] mid_q;
	logic [15:0] nfl_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIRECTION_RST;
			gain_q <= GLOW_GAIN_RST;
			mid_q <= GLOW_MID_RST;
			nfl_q <= NOISE_FLOOR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DIRECTION: dir_q <= cfg_data[0];
				REG_GLOW_GAIN: gain_q <= cfg_data;
				REG_GLOW_MID: mid_q <= cfg_data;
				REG_NOISE_FLOOR: nfl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: differences, saturation operands
	logic signed [31:0] r_in, g_in, b_in;
	logic signed [32:0] drg, dgb, dbr;
	logic signed [31:0] maxv, minv, mx0;
	logic [30:0] pmax, pmin;
	logic [NFW-1:0] nf_w, nf;
	logic [DEN_W-1:0] maxp, nfx;
	pix_t pix_d;

	assign r_in = pix_in.data.red_in;
	assign g_in = pix_in.data.green_in;
	assign b_in = pix_in.data.blue_in;
	assign drg = 33'(r_in) - 33'(g_in);
	assign dgb = 33'(g_in) - 33'(b_in);
	assign dbr = 33'(b_in) - 33'(r_in);
	assign mx0 = (r_in > g_in) ? r_in : g_in;
	assign maxv = (mx0 > b_in) ? mx0 : b_in;
	assign minv = (((r_in < g_in) ? r_in : g_in) < b_in) ? ((r_in < g_in) ? r_in : g_in) : b_in;
	assign pmax = maxv[31] ? '0 : maxv[30:0];
	assign pmin = minv[31] ? '0 : minv[30:0];
	assign nf_w = NFW'(({{FRAC_BITS{1'b0}}, nfl_q} << FRAC_BITS) >> 16);
	assign nf = (nf_w == '0) ? NFW'(1) : nf_w;
	assign maxp = DEN_W'(pmax);
	assign nfx = DEN_W'(nf);

	always_comb begin
		pix_d.valid = pix_in.valid;
		pix_d.last = pix_in.data.last_in;
		pix_d.alpha = pix_in.data.alpha_in;
		pix_d.r = r_in;
		pix_d.g = g_in;
		pix_d.b = b_in;
		pix_d.sum3 = SUM_W'(r_in) + SUM_W'(g_in) + SUM_W'(b_in);
	end

	pix_t pix_s1;
	logic [31:0] m_s1 [3];
	logic [30:0] num_s1;
	logic [DEN_W-1:0] den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else if (adv) begin
			pix_s1 <= pix_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1[0] <= drg[32] ? 32'(-drg) : drg[31:0];
			m_s1[1] <= dgb[32] ? 32'(-dgb) : dgb[31:0];
			m_s1[2] <= dbr[32] ? 32'(-dbr) : dbr[31:0];
			num_s1 <= pmax - pmin;
			den_s1 <= (maxp > nfx) ? maxp : nfx;
		end
	end

	// chroma radicand and root
	logic [RAD_W-1:0] sq_s2 [3];
	logic [RAD_W-1:0] rad_s3;
	logic [RAD_W+1:0] sq_sum;
	logic [SQ_STEPS-1:0] root_s35;

	assign sq_sum = (RAD_W+2)'(sq_s2[0]) + (RAD_W+2)'(sq_s2[1]) + (RAD_W+2)'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) sq_s2[i] <= RAD_W'(m_s1[i]) * RAD_W'(m_s1[i]);
			rad_s3 <= RAD_W'(sq_sum >> 3);
		end
	end

	swg_sqrt u_sqrt (.clk(clk), .en(adv), .rad(rad_s3), .root(root_s35));

	// saturation ratio and sigmoid
	logic [QW-1:0] satq_s31;
	logic [XW-1:0] x5, ax;
	logic [XW-1:0] half;
	logic xpos;
	logic [QW-1:0] t_s32, t2_s33, u33, sval;
	logic xpos_s32, xpos_s33;
	logic [2*QW-1:0] tt;
	logic [QW:0] s_sum;
	logic [GPW-1:0] gprod_s34;
	logic [QW-1:0] g34, g_s35;

	swg_div #(.W(DEN_W)) u_div_sat (
		.clk(clk), .en(adv), .num(DEN_W'(num_s1)), .den(den_s1), .quo(satq_s31)
	);

	assign x5 = (XW'(satq_s31) << 2) + XW'(satq_s31);
	assign xpos = (x5 >= (XW'(ONE) << 1));
	assign ax = xpos ? x5 - (XW'(ONE) << 1) : (XW'(ONE) << 1) - x5;
	assign half = ax >> 1;
	assign tt = (2*QW)'(t_s32) * (2*QW)'(t_s32);
	assign u33 = ONE - t2_s33;
	assign s_sum = xpos_s33 ? {1'b0, ONE} + {1'b0, u33} : {1'b0, ONE} - {1'b0, u33};
	assign sval = s_sum[QW:1];
	assign g34 = QW'(gprod_s34 >> 16);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s32 <= (half >= XW'(ONE)) ? '0 : QW'(XW'(ONE) - half);
			xpos_s32 <= xpos;
			t2_s33 <= QW'(tt >> QB);
			xpos_s33 <= xpos_s32;
			gprod_s34 <= GPW'(gain_q) * GPW'(sval);
		end
	end

	swg_delay #(.W(QW), .DEPTH(D_G_ALIGN)) u_dly_g0 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(g34), .q(g_s35)
	);

	pix_t pix_s35, pix_s99;

	swg_delay #(.W($bits(pix_t)), .DEPTH(D_PIX_A)) u_dly_pix_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(pix_s1), .q(pix_s35)
	);
	swg_delay #(.W($bits(pix_t)), .DEPTH(D_PIX_B)) u_dly_pix_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(pix_s35), .q(pix_s99)
	);

	// luma-plus-chroma against the glow ramp
	logic [35:0] c7;
	logic signed [NW-1:0] n4;
	logic signed [CW-1:0] a_s36;
	logic [GPW-1:0] prod8_s36;
	logic signed [CW-1:0] bm, bm8, bm24, thr;
	logic [TW-1:0] thrx;
	path_t flag_d, flag_s37, flag_s98;
	logic [WDIV_W-1:0] wn_s37, wd_s37;

	assign c7 = ({3'b0, root_s35, 1'b0} << 3) - {3'b0, root_s35, 1'b0};
	assign n4 = (NW'(pix_s35.sum3) <<< 2) + $signed(NW'(c7));
	assign bm = $signed(CW'(mid_q) << FRAC_BITS);
	assign bm8 = bm <<< 3;
	assign bm24 = (bm <<< 4) + (bm <<< 3);
	assign thrx = (TW'(prod8_s36) << (FRAC_BITS + 3)) >> QB;
	assign thr = bm8 + $signed(CW'(thrx));

	always_comb begin
		flag_d.ge24 = (a_s36 >= bm24);
		flag_d.le8 = (a_s36 <= bm8);
		flag_d.lethr = (a_s36 <= thr);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s36 <= CW'(n4) <<< 16;
			prod8_s36 <= GPW'(mid_q) * GPW'(g_s35);
			flag_s37 <= flag_d;
			wn_s37 <= WDIV_W'(bm24 - a_s36);
			wd_s37 <= WDIV_W'(a_s36 <<< 1);
		end
	end

	// inverse full-reduction quotient G / (1 + G)
	logic [QW-1:0] q0_s65, q0_s98;

	swg_div #(.W(QW)) u_div_q0 (
		.clk(clk), .en(adv), .num(g_s35), .den(ONE + g_s35), .quo(q0_s65)
	);
	swg_delay #(.W(QW), .DEPTH(D_Q0)) u_dly_q0 (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(q0_s65), .q(q0_s98)
	);

	// ramp weight and scaled gain
	logic [QW-1:0] w_s67, g_s67, g_s98, p68, p_s98, dv_s68, q2_s98;
	logic [2*QW-1:0] pprod_s68;

	swg_div #(.W(WDIV_W)) u_div_w (
		.clk(clk), .en(adv), .num(wn_s37), .den(wd_s37), .quo(w_s67)
	);
	swg_delay #(.W(QW), .DEPTH(D_G_A)) u_dly_g_a (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(g_s35), .q(g_s67)
	);
	swg_delay #(.W(QW), .DEPTH(D_G_B)) u_dly_g_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(g_s67), .q(g_s98)
	);
	swg_delay #(.W($bits(path_t)), .DEPTH(D_FLAG)) u_dly_flag (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(flag_s37), .q(flag_s98)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			pprod_s68 <= (2*QW)'(g_s67) * (2*QW)'(w_s67);
			dv_s68 <= ONE - (g_s67 >> 1);
		end
	end

	assign p68 = QW'(pprod_s68 >> QB);

	swg_div #(.W(QW)) u_div_q2 (
		.clk(clk), .en(adv), .num(p68), .den(dv_s68), .quo(q2_s98)
	);
	swg_delay #(.W(QW), .DEPTH(D_P)) u_dly_p (
		.clk(clk), .arst_n(arst_n), .en(adv), .d(p68), .q(p_s98)
	);

	// glow factor select
	logic [FW-1:0] fac_d, fac_s99;

	always_comb begin
		if (flag_s98.ge24) begin
			fac_d = FW'(ONE);
		end else if (!dir_q) begin
			fac_d = flag_s98.le8 ? FW'(ONE) + FW'(g_s98) : FW'(ONE) + FW'(p_s98);
		end else begin
			fac_d = flag_s98.lethr ? FW'(ONE) - FW'(q0_s98) : FW'(ONE) - FW'(q2_s98);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) fac_s99 <= fac_d;
	end

	// channel scaling, rounding and saturation
	logic signed [31:0] ch99 [3];
	logic [63:0] prod_s100 [3];
	logic neg_s100 [3];
	logic valid_s100, last_s100, valid_s101;
	logic [31:0] alpha_s100;
	logic [31:0] res101 [3];
	pix_out_t out_s101;

	assign ch99[0] = pix_s99.r;
	assign ch99[1] = pix_s99.g;
	assign ch99[2] = pix_s99.b;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				prod_s100[i] <= 64'(ch99[i][31] ? 32'(-33'(ch99[i])) : ch99[i][31:0])
					* 64'(fac_s99);
				neg_s100[i] <= ch99[i][31];
			end
			alpha_s100 <= pix_s99.alpha;
			last_s100 <= pix_s99.last;
		end
	end

	always_comb begin
		logic [34:0] qv;
		for (int i = 0; i < 3; i++) begin
			qv = 35'((prod_s100[i] + RND) >> QB);
			if (neg_s100[i]) begin
				res101[i] = (qv > 35'h080000000) ? 32'h80000000 : 32'(35'd0 - qv);
			end else begin
				res101[i] = (qv > 35'h07FFFFFFF) ? 32'h7FFFFFFF : qv[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s100 <= 1'b0;
			valid_s101 <= 1'b0;
		end else if (adv) begin
			valid_s100 <= pix_s99.valid;
			valid_s101 <= valid_s100;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s101.red_out <= res101[0];
			out_s101.green_out <= res101[1];
			out_s101.blue_out <= res101[2];
			out_s101.alpha_out <= alpha_s100;
			out_s101.last_out <= last_s100;
		end
	end

	// advance whenever the output register is free or being taken
	assign adv = !valid_s101 || pix_out.ready;
	assign pix_in.ready = adv;
	assign pix_out.valid = valid_s101;
	assign pix_out.data = out_s101;

	`SWG_ASSERT_SAME(a_stall_blocks_in, clk, arst_n, pix_out.valid && !pix_out.ready, !pix_in.ready, "input taken during output stall")
	`SWG_ASSERT_NEXT(a_entry_valid, clk, arst_n, adv, pix_s1.valid == $past(pix_in.valid), "entry valid does not follow transaction")
	`SWG_ASSERT_NEXT(a_no_glow_above_ramp, clk, arst_n, adv && flag_s98.ge24, fac_s99 == FW'(ONE), "factor not unity above glow ramp")

endmodule

`default_nettype wire

FILE: test/saturation_weighted_glow_unit_test.sv
// Self-checking testbench for saturation_weighted_glow_unit: pixels are driven
// through the stream interfaces and each output is checked against a glow model.
// Depends on swg_pkg, swg_stream_if and the unit itself.
`timescale 1ns / 1ps
`default_nettype none

module saturation_weighted_glow_unit_test;
	import swg_pkg::*;

	localparam bit [63:0] Q_ONE = 64'd1 << 30;
	localparam int PIPE_DRAIN = 130;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	swg_stream_if #(.T(pix_in_t)) pix_in_ch ();
	swg_stream_if #(.T(pix_out_t)) pix_out_ch ();

	saturation_weighted_glow_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.pix_in(pix_in_ch),
		.pix_out(pix_out_ch)
	);

	bit mdl_direction;
	bit [15:0] mdl_gain;
	bit [15:0] mdl_mid;
	bit [15:0] mdl_floor;

	pix_out_t glow_expected[$];
	int unsigned mismatches;
	int unsigned pixels_sent;
	int unsigned pixels_checked;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	function automatic bit [63:0] root64(bit [63:0] v);
		bit [63:0] res;
		bit [63:0] probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe >>= 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v -= res + probe;
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] qdiv(bit [63:0] n, bit [63:0] d);
		bit [63:0] q;
		bit [63:0] rem;
		q = 0;
		rem = n;
		if (d == 0 || n >= d)
			return Q_ONE;
		for (int i = 0; i < 30; i++) begin
			rem <<= 1;
			q <<= 1;
			if (rem >= d) begin
				rem -= d;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic bit [63:0] qmul(bit [63:0] x, bit [63:0] y);
		return (x >> 30) * y + (((x & (Q_ONE - 1)) * y) >> 30);
	endfunction

	function automatic bit [63:0] mag_sq(longint d);
		bit [63:0] m;
		m = d < 0 ? 64'(-d) : 64'(d);
		return m * m;
	endfunction

	function automatic logic [31:0] apply_gain(longint c, bit [63:0] f);
		bit [63:0] m;
		bit [63:0] q;
		m = c < 0 ? 64'(-c) : 64'(c);
		q = (m * f + (Q_ONE >> 1)) >> 30;
		if (c < 0) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return 32'(64'd0 - q);
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic pix_out_t glow_predict(pix_in_t p);
		longint r, g, b, n4, a, bm, maxv, minv, num, den, x, thr;
		bit [63:0] chroma, nf, satq, ax, half, t, t2, u, s, gg, fac, w, pp;
		bit [65:0] rad;
		pix_out_t o;
		r = p.red_in;
		g = p.green_in;
		b = p.blue_in;
		rad = 66'(mag_sq(r - g)) + 66'(mag_sq(g - b)) + 66'(mag_sq(b - r));
		chroma = 2 * root64(rad[65:3]);
		n4 = 4 * (r + g + b) + 7 * longint'(chroma);
		a = n4 * 65536;
		bm = longint'(mdl_mid) << 16;
		maxv = r > g ? r : g;
		maxv = maxv > b ? maxv : b;
		minv = r < g ? r : g;
		minv = minv < b ? minv : b;
		num = (maxv > 0 ? maxv : 0) - (minv > 0 ? minv : 0);
		nf = mdl_floor;
		if (nf < 1)
			nf = 1;
		den = maxv > longint'(nf) ? maxv : longint'(nf);
		satq = qdiv(64'(num), 64'(den));
		x = 5 * longint'(satq) - 2 * longint'(Q_ONE);
		ax = x < 0 ? 64'(-x) : 64'(x);
		half = ax >> 1;
		t = half >= Q_ONE ? 64'd0 : Q_ONE - half;
		t2 = (t * t) >> 30;
		u = Q_ONE - t2;
		s = x >= 0 ? (Q_ONE + u) >> 1 : (Q_ONE - u) >> 1;
		gg = (64'(mdl_gain) * s) >> 16;
		if (a >= 24 * bm) begin
			fac = Q_ONE;
		end else if (mdl_direction == 1'b0) begin
			if (a <= 8 * bm) begin
				fac = Q_ONE + gg;
			end else begin
				w = qdiv(64'(24 * bm - a), 64'(2 * a));
				fac = Q_ONE + qmul(gg, w);
			end
		end else begin
			thr = 8 * bm + longint'(qmul(64'(8 * bm), gg));
			if (a <= thr) begin
				fac = Q_ONE - qdiv(gg, Q_ONE + gg);
			end else begin
				w = qdiv(64'(24 * bm - a), 64'(2 * a));
				pp = qmul(gg, w);
				fac = Q_ONE - qdiv(pp, Q_ONE - (gg >> 1));
			end
		end
		o.red_out = apply_gain(r, fac);
		o.green_out = apply_gain(g, fac);
		o.blue_out = apply_gain(b, fac);
		o.alpha_out = p.alpha_in;
		o.last_out = p.last_in;
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("saturation_weighted_glow_unit regression: fail");
		$finish;
	end

	// output side: random stall, check each transaction
	always @(negedge clk) begin
		pix_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		pix_out_t got, want;
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready) begin
			got = pix_out_ch.data;
			if (glow_expected.size() == 0) begin
				$error("unexpected output transaction");
				mismatches++;
			end else begin
				want = glow_expected.pop_front();
				pixels_checked++;
				if (got.red_out !== want.red_out) begin
					$error("red_out: expected %h, got %h", want.red_out, got.red_out);
					mismatches++;
				end
				if (got.green_out !== want.green_out) begin
					$error("green_out: expected %h, got %h", want.green_out, got.green_out);
					mismatches++;
				end
				if (got.blue_out !== want.blue_out) begin
					$error("blue_out: expected %h, got %h", want.blue_out, got.blue_out);
					mismatches++;
				end
				if (got.alpha_out !== want.alpha_out) begin
					$error("alpha_out: expected %h, got %h", want.alpha_out, got.alpha_out);
					mismatches++;
				end
				if (got.last_out !== want.last_out) begin
					$error("last_out: expected %b, got %b", want.last_out, got.last_out);
					mismatches++;
				end
			end
		end
	end

	task automatic send_pixel(pix_in_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.data <= p;
		do
			@(posedge clk);
		while (!pix_in_ch.ready);
		glow_expected.push_back(glow_predict(p));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_rgb(int r, int g, int b);
		pix_in_t p;
		p.red_in = r;
		p.green_in = g;
		p.blue_in = b;
		p.alpha_in = $urandom;
		p.last_in = 1'($urandom_range(1));
		send_pixel(p);
	endtask

	task automatic drain;
		pix_in_ch.valid <= 1'b0;
		while (glow_expected.size() != 0)
			@(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		case (idx)
			REG_DIRECTION: mdl_direction = value[0];
			REG_GLOW_GAIN: mdl_gain = value;
			REG_GLOW_MID: mdl_mid = value;
			REG_NOISE_FLOOR: mdl_floor = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(bit dir, logic [15:0] gain, logic [15:0] mid, logic [15:0] nf);
		write_reg(REG_DIRECTION, {15'd0, dir});
		write_reg(REG_GLOW_GAIN, gain);
		write_reg(REG_GLOW_MID, mid);
		write_reg(REG_NOISE_FLOOR, nf);
	endtask

	function automatic int pick_channel();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $signed($urandom_range(32'h40000)) - 32'sh8000;
			2: return $urandom_range(1) ? 32'sh7FFF_FFFF - $urandom_range(255)
				: 32'sh8000_0000 + $urandom_range(255);
			default: return $urandom_range(32'h30000);
		endcase
	endfunction

	task automatic test_directed;
		send_rgb(0, 0, 0);
		send_rgb(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_rgb(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_rgb(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
		send_rgb(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_rgb(32'sh10000, 32'sh10000, 32'sh10000);
		send_rgb(6554, 6554, 6554);
		send_rgb(5 << 12, 3 << 12, 3 << 12);
		send_rgb(5, 3, 3);
		send_rgb(100, 0, 0);
		send_rgb(-100, -200, -300);
		send_rgb(3000, 1000, -2000);
		send_rgb(400, 0, 0);
		send_rgb(32'h18000, 32'h2000, 32'h1000);
		send_rgb(-1, -1, -1);
		set_all(1'b1, 16'hFFFF, 16'd0, 16'd1);
		send_rgb(0, 0, 0);
		send_rgb(-5000, 100, 200);
		send_rgb(32'sh7FFF_FFFF, 0, 0);
		send_rgb(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
		send_rgb(1, 0, 0);
		set_all(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_rgb(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_rgb(30000, 20000, 100);
		send_rgb(-30000, 20000, 100);
	endtask

	task automatic test_random_phase(int count);
		for (int i = 0; i < count; i++)
			send_rgb(pick_channel(), pick_channel(), pick_channel());
	endtask

	task automatic test_random;
		set_all(1'b0, GLOW_GAIN_RST, GLOW_MID_RST, NOISE_FLOOR_RST);
		test_random_phase(300);
		set_all(1'b1, GLOW_GAIN_RST, GLOW_MID_RST, NOISE_FLOOR_RST);
		test_random_phase(300);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_all(1'b0, 16'hFFFF, 16'hFFFF, 16'd1);
		test_random_phase(200);
		send_idle_pct = 9;
		recv_idle_pct = 9;
		set_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		test_random_phase(200);
		set_all(1'b0, 16'd0, 16'd0, 16'd1);
		test_random_phase(150);
		set_all(1'b1, 16'd0, 16'd0, 16'hFFFF);
		test_random_phase(150);
		for (int k = 0; k < 5; k++) begin
			set_all(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
				16'($urandom_range(16'hFFFF, 1)));
			test_random_phase(70);
			// hold off until every pending pixel is back
			pix_in_ch.valid <= 1'b0;
			while (glow_expected.size() != 0)
				@(negedge clk);
			test_random_phase(10);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_DIRECTION;
		cfg_data = '0;
		pix_in_ch.valid = 1'b0;
		pix_in_ch.data = '0;
		mdl_direction = DIRECTION_RST;
		mdl_gain = GLOW_GAIN_RST;
		mdl_mid = GLOW_MID_RST;
		mdl_floor = NOISE_FLOOR_RST;
		mismatches = 0;
		pixels_sent = 0;
		pixels_checked = 0;
		send_idle_pct = 9;
		recv_idle_pct = 9;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		drain();
		$display("Covered %0d pixels (%0d checked): both directions, gain/mid/floor extremes,",
			pixels_sent, pixels_checked);
		$display("full-range and near-black channels, random stalls on both sides.");
		if (mismatches == 0)
			$display("saturation_weighted_glow_unit regression: pass");
		else
			$display("saturation_weighted_glow_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
